// ===== hdl/pcicfg_pkg.sv =====
// ----------------------------------------------------------------------------
// PCI configuration header package
// Offsets, masks and reset values shared by the configuration header logic.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

    // Transaction kinds carried on the input tuser bit.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration space byte offsets.
    localparam logic [7:0] OFF_VENDOR_LO   = 8'h00;
    localparam logic [7:0] OFF_VENDOR_HI   = 8'h01;
    localparam logic [7:0] OFF_DEVICE_LO   = 8'h02;
    localparam logic [7:0] OFF_DEVICE_HI   = 8'h03;
    localparam logic [7:0] OFF_COMMAND_LO  = 8'h04;
    localparam logic [7:0] OFF_COMMAND_HI  = 8'h05;
    localparam logic [7:0] OFF_STATUS_LO   = 8'h06;
    localparam logic [7:0] OFF_STATUS_HI   = 8'h07;
    localparam logic [7:0] OFF_CLASS_HI    = 8'h0B;
    localparam logic [7:0] OFF_MMIO_BASE   = 8'h13;
    localparam logic [7:0] OFF_FB_BASE     = 8'h17;
    localparam logic [7:0] OFF_SUBSYS_0    = 8'h2C;
    localparam logic [7:0] OFF_SUBSYS_1    = 8'h2D;
    localparam logic [7:0] OFF_SUBSYS_2    = 8'h2E;
    localparam logic [7:0] OFF_SUBSYS_3    = 8'h2F;
    localparam logic [7:0] OFF_ROM_CTRL    = 8'h30;
    localparam logic [7:0] OFF_ROM_BASE_LO = 8'h32;
    localparam logic [7:0] OFF_ROM_BASE_HI = 8'h33;
    localparam logic [7:0] OFF_IRQ_LINE    = 8'h3C;
    localparam logic [7:0] OFF_IRQ_PIN     = 8'h3D;
    localparam logic [7:0] OFF_MIN_GNT     = 8'h3E;
    localparam logic [7:0] OFF_MAX_LAT     = 8'h3F;
    localparam logic [7:0] OFF_SUBSYS_W0   = 8'h40;
    localparam logic [7:0] OFF_SUBSYS_W1   = 8'h41;
    localparam logic [7:0] OFF_SUBSYS_W2   = 8'h42;
    localparam logic [7:0] OFF_SUBSYS_W3   = 8'h43;

    // Read and write masks.
    localparam logic [7:0] MASK_CMD_RD    = 8'h37;
    localparam logic [7:0] MASK_CMD_WR    = 8'h27;
    localparam logic [7:0] MASK_STAT_RD   = 8'h73;
    localparam logic [7:0] MASK_STAT_KEEP = 8'h8F;
    localparam logic [7:0] MASK_STAT_WR   = 8'h70;
    localparam logic [7:0] MASK_IRQ_WR    = 8'h0F;

    // Fixed read values.
    localparam logic [7:0] VAL_STATUS_LO = 8'h20;
    localparam logic [7:0] VAL_CLASS_HI  = 8'h03;
    localparam logic [7:0] VAL_IRQ_PIN   = 8'h01;
    localparam logic [7:0] VAL_MIN_GNT   = 8'h03;
    localparam logic [7:0] VAL_MAX_LAT   = 8'h01;

    // Reset values.
    localparam logic [15:0] RST_VENDOR    = 16'h12D2;
    localparam logic [15:0] RST_DEVICE    = 16'h0018;
    localparam logic [7:0]  RST_COMMAND   = 8'h07;
    localparam logic [7:0]  RST_STATUS_HI = 8'h02;
    localparam logic [7:0]  RST_ROM_LO    = 8'h0C;
    localparam logic [7:0]  RST_SUBSYS_0  = 8'hD2;
    localparam logic [7:0]  RST_SUBSYS_1  = 8'h12;
    localparam logic [7:0]  RST_SUBSYS_2  = 8'h00;
    localparam logic [7:0]  RST_SUBSYS_3  = 8'h03;

    // APB register indexes (word address bit 2).
    localparam logic REG_VENDOR = 1'b0;
    localparam logic REG_DEVICE = 1'b1;

    localparam int OUT_BITS = 48;

    // Decode window state.
    typedef struct packed {
        logic rom_on;
        logic fb_on;
        logic mmio_on;
        logic legacy_on;
        logic io_on;
    } t_windows;

endpackage

// ===== hdl/pci_config_space_registers.sv =====
// ----------------------------------------------------------------------------
// PCI configuration space registers
// Byte-wide type-0 configuration header of a video adapter with decode
// window tracking.
// ----------------------------------------------------------------------------
// Each input transaction is one configuration byte read or write. The block
// accepts one transaction per clock cycle and delivers its result in the cycle
// after acceptance from a single result register; a stalled output holds
// the input off only while that register is full and not being taken. The
// result carries the read byte (zero for writes) and the state of all decode
// windows and base addresses after the transaction. The vendor and device
// IDs are set through the APB port, which should only be written while no
// transaction is in flight.
module pci_config_space_registers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] reg_offset, [15:8] write_byte
    input  logic        s_axis_tuser,   // [0] cmd
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_byte, [8] io_decode_on, [9] legacy_window_on,
    // [10] mmio_window_on, [18:11] mmio_base_top, [19] fb_window_on,
    // [27:20] fb_base_top, [28] rom_window_on, [44:29] rom_base_top,
    // [47:45] zero
    output logic [47:0] m_axis_tdata
);
    import pcicfg_pkg::*;

    logic [15:0] r_vendor;
    logic [15:0] r_device;

    logic [7:0]  r_command,   n_command;
    logic        r_cmd_hi,    n_cmd_hi;
    logic [7:0]  r_status_hi, n_status_hi;
    logic [7:0]  r_mmio_base, n_mmio_base;
    logic [7:0]  r_fb_base,   n_fb_base;
    logic [7:0]  r_subsys [4];
    logic [7:0]  r_rom_ctrl,  n_rom_ctrl;
    logic [7:0]  r_rom_lo,    n_rom_lo;
    logic [7:0]  r_rom_hi,    n_rom_hi;
    logic [3:0]  r_irq_line,  n_irq_line;
    t_windows    r_win,       n_win;

    logic        r_out_valid;
    logic [OUT_BITS-1:0] r_out_data, n_out_data;

    logic        cfg_wr;
    logic        in_acc;
    logic        is_write;
    logic [7:0]  offset;
    logic [7:0]  wbyte;
    logic [7:0]  rd_byte;
    logic        subsys_wr;

    // APB side
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_DEVICE) ? {16'h0, r_device} : {16'h0, r_vendor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor <= RST_VENDOR;
            r_device <= RST_DEVICE;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_VENDOR) begin
                r_vendor <= pwdata[15:0];
            end else begin
                r_device <= pwdata[15:0];
            end
        end
    end

    // Stream side
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_write      = (s_axis_tuser == CMD_WRITE);
    assign offset        = s_axis_tdata[7:0];
    assign wbyte         = s_axis_tdata[15:8];

    // Read decode
    always_comb begin
        case (offset)
            OFF_VENDOR_LO:   rd_byte = r_vendor[7:0];
            OFF_VENDOR_HI:   rd_byte = r_vendor[15:8];
            OFF_DEVICE_LO:   rd_byte = r_device[7:0];
            OFF_DEVICE_HI:   rd_byte = r_device[15:8];
            OFF_COMMAND_LO:  rd_byte = r_command & MASK_CMD_RD;
            OFF_COMMAND_HI:  rd_byte = {7'h0, r_cmd_hi};
            OFF_STATUS_LO:   rd_byte = VAL_STATUS_LO;
            OFF_STATUS_HI:   rd_byte = r_status_hi & MASK_STAT_RD;
            OFF_CLASS_HI:    rd_byte = VAL_CLASS_HI;
            OFF_MMIO_BASE:   rd_byte = r_mmio_base;
            OFF_FB_BASE:     rd_byte = r_fb_base;
            OFF_SUBSYS_0,
            OFF_SUBSYS_1,
            OFF_SUBSYS_2,
            OFF_SUBSYS_3:    rd_byte = r_subsys[offset[1:0]];
            OFF_ROM_CTRL:    rd_byte = {7'h0, r_rom_ctrl[0]};
            OFF_ROM_BASE_LO: rd_byte = r_rom_lo;
            OFF_ROM_BASE_HI: rd_byte = r_rom_hi;
            OFF_IRQ_LINE:    rd_byte = {4'h0, r_irq_line};
            OFF_IRQ_PIN:     rd_byte = VAL_IRQ_PIN;
            OFF_MIN_GNT:     rd_byte = VAL_MIN_GNT;
            OFF_MAX_LAT:     rd_byte = VAL_MAX_LAT;
            default:         rd_byte = 8'h00;
        endcase
    end

    // Write decode and window updates
    always_comb begin
        n_command   = r_command;
        n_cmd_hi    = r_cmd_hi;
        n_status_hi = r_status_hi;
        n_mmio_base = r_mmio_base;
        n_fb_base   = r_fb_base;
        n_rom_ctrl  = r_rom_ctrl;
        n_rom_lo    = r_rom_lo;
        n_rom_hi    = r_rom_hi;
        n_irq_line  = r_irq_line;
        n_win       = r_win;
        subsys_wr   = 1'b0;
        if (is_write) begin
            case (offset)
                OFF_COMMAND_LO: begin
                    n_command       = wbyte & MASK_CMD_WR;
                    // A command write closes every window but the ROM one and
                    // reopens them from the IO and memory enables.
                    n_win.io_on     = wbyte[0];
                    n_win.legacy_on = wbyte[1] && (r_mmio_base == 8'h0)
                                      && (r_fb_base == 8'h0);
                    n_win.mmio_on   = wbyte[1] && (r_mmio_base != 8'h0);
                    n_win.fb_on     = wbyte[1] && (r_fb_base != 8'h0);
                end
                OFF_COMMAND_HI: n_cmd_hi = wbyte[0];
                OFF_STATUS_HI: begin
                    n_status_hi = (r_status_hi & MASK_STAT_KEEP) | (wbyte & MASK_STAT_WR);
                end
                OFF_MMIO_BASE: begin
                    n_mmio_base   = wbyte;
                    n_win.mmio_on = (wbyte != 8'h0);
                end
                OFF_FB_BASE: begin
                    n_fb_base   = wbyte;
                    n_win.fb_on = (wbyte != 8'h0);
                end
                OFF_ROM_CTRL: begin
                    n_rom_ctrl   = wbyte;
                    n_win.rom_on = wbyte[0];
                end
                OFF_ROM_BASE_LO: begin
                    n_rom_lo     = wbyte;
                    n_win.rom_on = r_rom_ctrl[0];
                end
                OFF_ROM_BASE_HI: begin
                    n_rom_hi     = wbyte;
                    n_win.rom_on = r_rom_ctrl[0];
                end
                OFF_IRQ_LINE: n_irq_line = wbyte[3:0];
                OFF_SUBSYS_W0,
                OFF_SUBSYS_W1,
                OFF_SUBSYS_W2,
                OFF_SUBSYS_W3: subsys_wr = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out_data = {3'h0, n_rom_hi, n_rom_lo, n_win.rom_on, n_fb_base, n_win.fb_on,
                      n_mmio_base, n_win.mmio_on, n_win.legacy_on, n_win.io_on,
                      (is_write ? 8'h00 : rd_byte)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command   <= RST_COMMAND;
            r_cmd_hi    <= 1'b0;
            r_status_hi <= RST_STATUS_HI;
            r_mmio_base <= 8'h00;
            r_fb_base   <= 8'h00;
            r_subsys[0] <= RST_SUBSYS_0;
            r_subsys[1] <= RST_SUBSYS_1;
            r_subsys[2] <= RST_SUBSYS_2;
            r_subsys[3] <= RST_SUBSYS_3;
            r_rom_ctrl  <= 8'h00;
            r_rom_lo    <= RST_ROM_LO;
            r_rom_hi    <= 8'h00;
            r_irq_line  <= 4'h0;
            r_win       <= '{rom_on: 1'b0, fb_on: 1'b0, mmio_on: 1'b0,
                             legacy_on: 1'b1, io_on: 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_command   <= n_command;
                r_cmd_hi    <= n_cmd_hi;
                r_status_hi <= n_status_hi;
                r_mmio_base <= n_mmio_base;
                r_fb_base   <= n_fb_base;
                r_rom_ctrl  <= n_rom_ctrl;
                r_rom_lo    <= n_rom_lo;
                r_rom_hi    <= n_rom_hi;
                r_irq_line  <= n_irq_line;
                r_win       <= n_win;
                if (subsys_wr) begin
                    r_subsys[offset[1:0]] <= wbyte;
                end
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== dv/pci_config_space_registers_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI configuration header testbench
// Drives byte-wide configuration reads and writes into the header, predicts
// every result (read byte plus decode window and base state), and checks the
// result stream field by field. The vendor and device IDs are reprogrammed
// over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module pci_config_space_registers_test;
    import pcicfg_pkg::*;

    typedef struct {
        logic       wr;
        logic [7:0] off;
        logic [7:0] data;
    } t_cfg_access;

    // Mirrors the result tdata layout, lowest field last.
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] rom_base;
        logic        rom_on;
        logic [7:0]  fb_base;
        logic        fb_on;
        logic [7:0]  mmio_base;
        logic        mmio_on;
        logic        legacy_on;
        logic        io_on;
        logic [7:0]  read_byte;
    } t_cfg_result;

    localparam int NUM_KNOWN = 30;
    localparam logic [7:0] KNOWN_OFFSETS [NUM_KNOWN] = '{
        OFF_VENDOR_LO, OFF_VENDOR_HI, OFF_DEVICE_LO, OFF_DEVICE_HI,
        OFF_COMMAND_LO, OFF_COMMAND_HI, OFF_STATUS_LO, OFF_STATUS_HI,
        OFF_CLASS_HI, OFF_MMIO_BASE, OFF_FB_BASE, OFF_SUBSYS_0,
        OFF_SUBSYS_1, OFF_SUBSYS_2, OFF_SUBSYS_3, OFF_ROM_CTRL,
        OFF_ROM_BASE_LO, OFF_ROM_BASE_HI, OFF_IRQ_LINE, OFF_IRQ_PIN,
        OFF_MIN_GNT, OFF_MAX_LAT, OFF_SUBSYS_W0, OFF_SUBSYS_W1,
        OFF_SUBSYS_W2, OFF_SUBSYS_W3, OFF_MMIO_BASE, OFF_FB_BASE,
        OFF_COMMAND_LO, OFF_ROM_CTRL
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] reg_offset, [15:8] write_byte
    logic        s_axis_tuser = CMD_READ;   // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] read_byte, [8] io_decode_on, [9] legacy_window_on,
    // [10] mmio_window_on, [18:11] mmio_base_top, [19] fb_window_on,
    // [27:20] fb_base_top, [28] rom_window_on, [44:29] rom_base_top
    logic [47:0] m_axis_tdata;

    pci_config_space_registers dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Header state as predicted.
    logic [15:0] pred_vendor;
    logic [15:0] pred_device;
    logic [7:0]  command_reg;
    logic        command_hi;
    logic [7:0]  status_hi;
    logic [7:0]  mmio_base;
    logic [7:0]  fb_base;
    logic [7:0]  subsys_id [4];
    logic [7:0]  rom_ctrl;
    logic [7:0]  rom_lo;
    logic [7:0]  rom_hi;
    logic [3:0]  irq_line;
    t_windows    windows;

    t_cfg_access pending_accesses [$];
    t_cfg_result predicted_results [$];
    int          error_count = 0;
    bit          steady = 1'b0;

    task automatic reset_header();
        pred_vendor = RST_VENDOR;
        pred_device = RST_DEVICE;
        command_reg = RST_COMMAND;
        command_hi  = 1'b0;
        status_hi   = RST_STATUS_HI;
        mmio_base   = '0;
        fb_base     = '0;
        subsys_id   = '{RST_SUBSYS_0, RST_SUBSYS_1, RST_SUBSYS_2, RST_SUBSYS_3};
        rom_ctrl    = '0;
        rom_lo      = RST_ROM_LO;
        rom_hi      = '0;
        irq_line    = '0;
        windows     = '0;
        windows.io_on     = 1'b1;
        windows.legacy_on = 1'b1;
    endtask

    task automatic predict_access(input t_cfg_access acc, output t_cfg_result res);
        logic [7:0] rd;
        logic       rom_keep;
        rd = '0;
        if (acc.wr == CMD_WRITE) begin
            case (acc.off)
                OFF_COMMAND_LO: begin
                    command_reg = acc.data & MASK_CMD_WR;
                    // Every window but the ROM one closes, then reopens by IO and memory.
                    rom_keep = windows.rom_on;
                    windows = '0;
                    windows.rom_on = rom_keep;
                    windows.io_on = acc.data[0];
                    if (acc.data[1]) begin
                        windows.legacy_on = (mmio_base == 8'h00) && (fb_base == 8'h00);
                        windows.mmio_on   = (mmio_base != 8'h00);
                        windows.fb_on     = (fb_base != 8'h00);
                    end
                end
                OFF_COMMAND_HI: command_hi = acc.data[0];
                OFF_STATUS_HI:  status_hi = (status_hi & MASK_STAT_KEEP)
                                            | (acc.data & MASK_STAT_WR);
                OFF_MMIO_BASE: begin
                    mmio_base = acc.data;
                    windows.mmio_on = (acc.data != 8'h00);
                end
                OFF_FB_BASE: begin
                    fb_base = acc.data;
                    windows.fb_on = (acc.data != 8'h00);
                end
                OFF_ROM_CTRL, OFF_ROM_BASE_LO, OFF_ROM_BASE_HI: begin
                    if (acc.off == OFF_ROM_CTRL)
                        rom_ctrl = acc.data;
                    else if (acc.off == OFF_ROM_BASE_LO)
                        rom_lo = acc.data;
                    else
                        rom_hi = acc.data;
                    windows.rom_on = rom_ctrl[0];
                end
                OFF_IRQ_LINE: irq_line = acc.data[3:0] & MASK_IRQ_WR[3:0];
                OFF_SUBSYS_W0, OFF_SUBSYS_W1, OFF_SUBSYS_W2, OFF_SUBSYS_W3:
                    subsys_id[acc.off[1:0]] = acc.data;
                default: ;
            endcase
        end else begin
            case (acc.off)
                OFF_VENDOR_LO:   rd = pred_vendor[7:0];
                OFF_VENDOR_HI:   rd = pred_vendor[15:8];
                OFF_DEVICE_LO:   rd = pred_device[7:0];
                OFF_DEVICE_HI:   rd = pred_device[15:8];
                OFF_COMMAND_LO:  rd = command_reg & MASK_CMD_RD;
                OFF_COMMAND_HI:  rd = {7'd0, command_hi};
                OFF_STATUS_LO:   rd = VAL_STATUS_LO;
                OFF_STATUS_HI:   rd = status_hi & MASK_STAT_RD;
                OFF_CLASS_HI:    rd = VAL_CLASS_HI;
                OFF_MMIO_BASE:   rd = mmio_base;
                OFF_FB_BASE:     rd = fb_base;
                OFF_SUBSYS_0, OFF_SUBSYS_1, OFF_SUBSYS_2, OFF_SUBSYS_3:
                    rd = subsys_id[acc.off[1:0]];
                OFF_ROM_CTRL:    rd = {7'd0, rom_ctrl[0]};
                OFF_ROM_BASE_LO: rd = rom_lo;
                OFF_ROM_BASE_HI: rd = rom_hi;
                OFF_IRQ_LINE:    rd = {4'd0, irq_line};
                OFF_IRQ_PIN:     rd = VAL_IRQ_PIN;
                OFF_MIN_GNT:     rd = VAL_MIN_GNT;
                OFF_MAX_LAT:     rd = VAL_MAX_LAT;
                default:         rd = '0;
            endcase
        end
        res.pad       = '0;
        res.read_byte = rd;
        res.io_on     = windows.io_on;
        res.legacy_on = windows.legacy_on;
        res.mmio_on   = windows.mmio_on;
        res.mmio_base = mmio_base;
        res.fb_on     = windows.fb_on;
        res.fb_base   = fb_base;
        res.rom_on    = windows.rom_on;
        res.rom_base  = {rom_hi, rom_lo};
    endtask

    // Input side: one transaction per accepted handshake.
    always @(posedge i_clk) begin
        t_cfg_access acc;
        t_cfg_result res;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                acc.wr   = s_axis_tuser;
                acc.off  = s_axis_tdata[7:0];
                acc.data = s_axis_tdata[15:8];
                predict_access(acc, res);
                predicted_results.push_back(res);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_accesses.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
                    acc = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= acc.wr;
                    s_axis_tdata  <= {acc.data, acc.off};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: check against the oldest prediction.
    always @(posedge i_clk) begin
        t_cfg_result got;
        t_cfg_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_cfg_result'(m_axis_tdata);
                if (predicted_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: result with nothing predicted: %h", $realtime, got);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.read_byte !== want.read_byte || got.io_on !== want.io_on ||
                        got.legacy_on !== want.legacy_on || got.mmio_on !== want.mmio_on ||
                        got.mmio_base !== want.mmio_base || got.fb_on !== want.fb_on ||
                        got.fb_base !== want.fb_base || got.rom_on !== want.rom_on ||
                        got.rom_base !== want.rom_base || got.pad !== want.pad) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: mismatch, got %h expected %h",
                                     $realtime, got, want);
                    end
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 6);
        end
    end

    function automatic void push_access(input logic wr, input logic [7:0] off,
                                        input logic [7:0] data);
        t_cfg_access acc;
        acc.wr   = wr;
        acc.off  = off;
        acc.data = data;
        pending_accesses.push_back(acc);
    endfunction

    function automatic logic [7:0] random_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 8'h00;
        else if (pick < 22)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] random_offset();
        if ($urandom_range(99) < 75)
            return KNOWN_OFFSETS[$urandom_range(NUM_KNOWN - 1)];
        return 8'($urandom_range(255));
    endfunction

    // Returns the number of transactions queued.
    function automatic int push_random();
        if ($urandom_range(99) < 15) begin
            // Base write, then a command write that sets the windows anew from its enables, then a read.
            push_access(CMD_WRITE, $urandom_range(1) ? OFF_MMIO_BASE : OFF_FB_BASE,
                        random_byte());
            push_access(CMD_WRITE, OFF_COMMAND_LO, random_byte());
            push_access(CMD_READ, random_offset(), random_byte());
            return 3;
        end
        push_access($urandom_range(1) ? CMD_WRITE : CMD_READ, random_offset(), random_byte());
        return 1;
    endfunction

    // Waits until every queued transaction has been taken and answered. The
    // queues are looked at on the falling edge, once the drivers have settled.
    task automatic wait_drained();
        while (pending_accesses.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic index, input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_VENDOR)
            pred_vendor = value;
        else
            pred_device = value;
    endtask

    initial begin
        logic [15:0] vendor_setting [4];
        logic [15:0] device_setting [4];
        int queued;
        vendor_setting = '{16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom)};
        device_setting = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};
        reset_header();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass with the reset IDs.
        push_access(CMD_READ,  OFF_VENDOR_LO,  8'h00);
        push_access(CMD_READ,  OFF_VENDOR_HI,  8'hFF);
        push_access(CMD_READ,  OFF_DEVICE_LO,  8'h00);
        push_access(CMD_READ,  OFF_DEVICE_HI,  8'h00);
        push_access(CMD_WRITE, OFF_VENDOR_LO,  8'hFF);
        push_access(CMD_READ,  OFF_VENDOR_LO,  8'h00);
        push_access(CMD_WRITE, OFF_COMMAND_LO, 8'hFF);
        push_access(CMD_READ,  OFF_COMMAND_LO, 8'h00);
        push_access(CMD_WRITE, OFF_MMIO_BASE,  8'hA5);
        push_access(CMD_WRITE, OFF_FB_BASE,    8'h5A);
        push_access(CMD_WRITE, OFF_COMMAND_LO, 8'h02);
        push_access(CMD_WRITE, OFF_MMIO_BASE,  8'h00);
        // The subsystem IDs are written only through their alias bytes.
        push_access(CMD_WRITE, OFF_SUBSYS_W0,  8'h11);
        push_access(CMD_READ,  OFF_SUBSYS_W0,  8'h00);
        push_access(CMD_READ,  OFF_SUBSYS_0,   8'h00);
        push_access(CMD_WRITE, OFF_SUBSYS_1,   8'h77);
        push_access(CMD_READ,  OFF_SUBSYS_1,   8'h00);
        push_access(CMD_WRITE, OFF_ROM_CTRL,   8'h01);
        push_access(CMD_WRITE, OFF_ROM_BASE_HI, 8'hFF);
        push_access(CMD_READ,  OFF_ROM_CTRL,   8'h00);
        push_access(CMD_WRITE, OFF_STATUS_HI,  8'hFF);
        push_access(CMD_READ,  OFF_STATUS_HI,  8'h00);
        push_access(CMD_WRITE, OFF_IRQ_LINE,   8'hFF);
        push_access(CMD_READ,  OFF_IRQ_LINE,   8'h00);
        push_access(CMD_WRITE, 8'hFF,          8'hFF);
        push_access(CMD_READ,  8'hFF,          8'h00);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            apb_write(REG_VENDOR, vendor_setting[phase]);
            apb_write(REG_DEVICE, device_setting[phase]);
            steady = (phase == 2);
            queued = 0;
            while (queued < 400)
                queued += push_random();
            wait_drained();
        end

        if (error_count == 0 && predicted_results.size() == 0)
            $display("pci_config_space_registers_test: clean");
        else
            $display("pci_config_space_registers_test: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("pci_config_space_registers_test: errors");
        $finish;
    end

endmodule
